// ===== hdl/dbpam_pkg.sv =====
// Widths and stage types shared by the diboson polar angle and mass pipeline.
package dbpam_pkg;

   localparam int MOMENTUM_WIDTH = 24;
   localparam int W              = MOMENTUM_WIDTH;
   localparam int ENERGY_W       = W - 1;
   localparam int SUM_W          = W + 1;
   localparam int SQ_W           = 2 * W + 1;
   localparam int DP_W           = 2 * W + 1;
   localparam int PP_W           = 2 * W - 1;
   localparam int SEE_W          = 2 * W;
   localparam int PPAIR_W        = 2 * W + 2;
   localparam int M2_W           = 2 * W;
   localparam int DOT_W          = 2 * W + 3;
   localparam int DMAG_W         = 2 * W + 1;
   localparam int PONE_W         = 2 * W;
   localparam int PART_W         = 2 * W + 2;
   localparam int EA_W           = 3 * W + 1;
   localparam int AMAG_W         = 3 * W + 2;
   localparam int C_W            = 4 * W + 2;
   localparam int A2_W           = 6 * W + 4;
   localparam int MC_W           = 6 * W + 2;
   localparam int D_W            = 6 * W + 5;
   localparam int ANGLE_W        = 16;
   localparam int Q_W            = 2 * ANGLE_W + 1;
   localparam int CQ_W           = ANGLE_W + 1;
   localparam int CX_W           = 2 * CQ_W;
   localparam int CR_W           = CQ_W + 2;
   localparam int MR_W           = W + 2;
   localparam int LONG_STEPS     = Q_W + CQ_W;
   localparam int FRONT_STAGES   = 8;
   localparam int NSTAGE         = FRONT_STAGES + LONG_STEPS + 2;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;

   typedef struct packed {
      logic            bad;
      logic [D_W-1:0]  den;
      logic [D_W:0]    rem;
      logic [Q_W-1:0]  quo;
      logic [M2_W-1:0] mx;
      logic [MR_W-1:0] mr;
      logic [W-1:0]    mq;
      logic [CX_W-1:0] cx;
      logic [CR_W-1:0] cr;
      logic [CQ_W-1:0] cq;
   } dbpam_stage_type;

endpackage

// ===== hdl/diboson_polar_angle_and_mass.sv =====
// Diboson pair mass and rest-frame polar angle, fully pipelined.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | two boson four-vectors
//  rsp     | out       | rsp_valid, rsp_stall | pair_mass, abs_cos_angle, result_valid
//
// One transaction per cycle while the result is not stalled; the stages are eight
// arithmetic stages, one denominator stage, 33 long-division steps, 17 square-root steps
// for the angle and one output stage.
// The division chain, one quotient bit per stage, and the angle square root after it set the depth.
// Reset clears the stage valid bits only.
// A stalled result freezes the whole pipeline; req_stall follows it.
module diboson_polar_angle_and_mass (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_plus_px,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_plus_py,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_plus_pz,
   input  logic        [dbpam_pkg::ENERGY_W-1:0]       req_plus_energy,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_minus_px,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_minus_py,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_minus_pz,
   input  logic        [dbpam_pkg::ENERGY_W-1:0]       req_minus_energy,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic        [dbpam_pkg::MOMENTUM_WIDTH-1:0] rsp_pair_mass,
   output logic        [dbpam_pkg::ANGLE_W-1:0]        rsp_abs_cos_angle,
   output logic                                        rsp_result_valid
);
   import dbpam_pkg::*;

   logic adv;
   logic [NSTAGE-1:0] vld_ff;

   logic signed [W-1:0]     s1_p_ff [3];
   logic signed [SUM_W-1:0] s1_s_ff [3];
   logic signed [W-1:0]     s1_p_in [3];
   logic signed [SUM_W-1:0] s1_s_in [3];
   logic [ENERGY_W-1:0]     s1_pe_ff;
   logic [W-1:0]            s1_se_ff;
   logic [W-1:0]            s1_se_in;

   logic [SQ_W-1:0]        s2_sq_ff [3];
   logic [SQ_W-1:0]        s2_sq_in [3];
   logic signed [DP_W-1:0] s2_dp_ff [3];
   logic signed [DP_W-1:0] s2_dp_in [3];
   logic [PP_W-1:0]        s2_pp_ff [3];
   logic [PP_W-1:0]        s2_pp_in [3];
   logic [SEE_W-1:0]       s2_see_ff;
   logic [SEE_W-1:0]       s2_see_in;
   logic [W-1:0]           s2_se_ff;
   logic [ENERGY_W-1:0]    s2_pe_ff;

   logic [PPAIR_W-1:0]  s3_ppair_ff, s3_ppair_in;
   logic [M2_W-1:0]     s3_m2_ff, s3_m2_in;
   logic                s3_bad_ff, s3_bad_in;
   logic [DMAG_W-1:0]   s3_dmag_ff, s3_dmag_in;
   logic                s3_dneg_ff, s3_dneg_in;
   logic [PONE_W-1:0]   s3_pone_ff, s3_pone_in;
   logic [W-1:0]        s3_se_ff;
   logic [ENERGY_W-1:0] s3_pe_ff;

   logic [PART_W-1:0] s4_ea_lo_ff, s4_ea_hi_ff, s4_pb_lo_ff, s4_pb_hi_ff;
   logic [PART_W-1:0] s4_ea_lo_in, s4_ea_hi_in, s4_pb_lo_in, s4_pb_hi_in;
   logic [PART_W-1:0] s4_cp_ff [4];
   logic [PART_W-1:0] s4_cp_in [4];
   logic [PART_W-1:0] s4_dd_ff [3];
   logic [PART_W-1:0] s4_dd_in [3];
   logic [M2_W-1:0]   s4_m2_ff;
   logic              s4_bad_ff, s4_dneg_ff;

   logic [EA_W-1:0] s5_ea_ff, s5_ea_in, s5_pb_ff, s5_pb_in;
   logic [C_W-1:0]  s5_prod_ff, s5_prod_in, s5_dsq_ff, s5_dsq_in;
   logic [M2_W-1:0] s5_m2_ff;
   logic            s5_bad_ff, s5_dneg_ff;

   logic [AMAG_W-1:0]        s6_amag_ff, s6_amag_in;
   logic [C_W-1:0]           s6_c_ff, s6_c_in;
   logic [M2_W-1:0]          s6_m2_ff;
   logic                     s6_bad_ff;
   logic [AMAG_W-1:0]        a_sum;
   logic signed [AMAG_W-1:0] a_diff;

   logic [PART_W-1:0] s7_ap_ff [6];
   logic [PART_W-1:0] s7_ap_in [6];
   logic [PART_W-1:0] s7_mc_ff [8];
   logic [PART_W-1:0] s7_mc_in [8];
   logic [M2_W-1:0]   s7_m2_ff;
   logic              s7_bad_ff;

   logic [A2_W-1:0] s8_a2_ff, s8_a2_in;
   logic [MC_W-1:0] s8_mc_ff, s8_mc_in;
   logic [M2_W-1:0] s8_m2_ff;
   logic            s8_bad_ff;

   dbpam_stage_type lane_ff [0:LONG_STEPS];
   dbpam_stage_type lane_in [0:LONG_STEPS];

   logic [W-1:0]       rsp_pair_mass_ff, rsp_pair_mass_in;
   logic [ANGLE_W-1:0] rsp_angle_ff, rsp_angle_in;
   logic               rsp_ok_ff, rsp_ok_in;

   assign rsp_valid         = vld_ff[NSTAGE-1];
   assign adv               = !(rsp_valid && rsp_stall);
   assign req_stall         = !adv;
   assign rsp_pair_mass     = rsp_pair_mass_ff;
   assign rsp_abs_cos_angle = rsp_angle_ff;
   assign rsp_result_valid  = rsp_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_valid};
      end
   end

   // stage 1: pair sums
   always_comb begin
      s1_p_in[0] = req_plus_px;
      s1_p_in[1] = req_plus_py;
      s1_p_in[2] = req_plus_pz;
      s1_s_in[0] = SUM_W'(req_plus_px) + SUM_W'(req_minus_px);
      s1_s_in[1] = SUM_W'(req_plus_py) + SUM_W'(req_minus_py);
      s1_s_in[2] = SUM_W'(req_plus_pz) + SUM_W'(req_minus_pz);
      s1_se_in   = W'(req_plus_energy) + W'(req_minus_energy);
   end

   // stage 2: component products
   always_comb begin
      logic signed [PPAIR_W-1:0] sq_full;
      logic signed [SEE_W-1:0]   pp_full;
      s2_see_in = s1_se_ff * s1_se_ff;
      for (int i = 0; i < 3; i++) begin
         sq_full     = s1_s_ff[i] * s1_s_ff[i];
         pp_full     = s1_p_ff[i] * s1_p_ff[i];
         s2_sq_in[i] = sq_full[SQ_W-1:0];
         s2_pp_in[i] = pp_full[PP_W-1:0];
         s2_dp_in[i] = s1_p_ff[i] * s1_s_ff[i];
      end
   end

   // stage 3: dot products and mass squared
   always_comb begin
      logic signed [PPAIR_W:0] m2;
      logic signed [DOT_W-1:0] dot;
      logic signed [DOT_W-1:0] dabs;
      s3_ppair_in = PPAIR_W'(s2_sq_ff[0]) + PPAIR_W'(s2_sq_ff[1]) + PPAIR_W'(s2_sq_ff[2]);
      m2          = $signed({3'b000, s2_see_ff}) - $signed({1'b0, s3_ppair_in});
      dot         = DOT_W'(s2_dp_ff[0]) + DOT_W'(s2_dp_ff[1]) + DOT_W'(s2_dp_ff[2]);
      dabs        = dot[DOT_W-1] ? -dot : dot;
      s3_m2_in    = m2[M2_W-1:0];
      s3_bad_in   = m2[PPAIR_W] || (m2 == '0) || (s3_ppair_in == '0);
      s3_dneg_in  = dot[DOT_W-1];
      s3_dmag_in  = dabs[DMAG_W-1:0];
      s3_pone_in  = PONE_W'(s2_pp_ff[0]) + PONE_W'(s2_pp_ff[1]) + PONE_W'(s2_pp_ff[2]);
   end

   // stage 4: partial products
   always_comb begin
      s4_ea_lo_in = s3_se_ff * s3_dmag_ff[24:0];
      s4_ea_hi_in = s3_se_ff * s3_dmag_ff[48:25];
      s4_pb_lo_in = s3_ppair_ff[24:0] * s3_pe_ff;
      s4_pb_hi_in = s3_ppair_ff[49:25] * s3_pe_ff;
      s4_cp_in[0] = s3_pone_ff[23:0] * s3_ppair_ff[24:0];
      s4_cp_in[1] = s3_pone_ff[23:0] * s3_ppair_ff[49:25];
      s4_cp_in[2] = s3_pone_ff[47:24] * s3_ppair_ff[24:0];
      s4_cp_in[3] = s3_pone_ff[47:24] * s3_ppair_ff[49:25];
      s4_dd_in[0] = s3_dmag_ff[24:0] * s3_dmag_ff[24:0];
      s4_dd_in[1] = s3_dmag_ff[24:0] * s3_dmag_ff[48:25];
      s4_dd_in[2] = s3_dmag_ff[48:25] * s3_dmag_ff[48:25];
   end

   // stage 5: combine partial products
   always_comb begin
      s5_ea_in   = EA_W'(s4_ea_lo_ff) + (EA_W'(s4_ea_hi_ff) << 25);
      s5_pb_in   = EA_W'(s4_pb_lo_ff) + (EA_W'(s4_pb_hi_ff) << 25);
      s5_prod_in = C_W'(s4_cp_ff[0]) + (C_W'(s4_cp_ff[1]) << 25)
                 + (C_W'(s4_cp_ff[2]) << 24) + (C_W'(s4_cp_ff[3]) << 49);
      s5_dsq_in  = C_W'(s4_dd_ff[0]) + (C_W'(s4_dd_ff[1]) << 26)
                 + (C_W'(s4_dd_ff[2]) << 50);
   end

   // stage 6: |A| and C
   always_comb begin
      a_sum  = AMAG_W'(s5_ea_ff) + AMAG_W'(s5_pb_ff);
      a_diff = $signed({1'b0, s5_ea_ff}) - $signed({1'b0, s5_pb_ff});
      if (s5_dneg_ff) begin
         s6_amag_in = a_sum;
      end else if (a_diff[AMAG_W-1]) begin
         s6_amag_in = $unsigned(-a_diff);
      end else begin
         s6_amag_in = $unsigned(a_diff);
      end
      s6_c_in = s5_prod_ff - s5_dsq_ff;
   end

   // stage 7: partial products of A^2 and m2*C
   always_comb begin
      logic [24:0] al [3];
      logic [24:0] cl [4];
      logic [23:0] ml [2];
      al[0] = s6_amag_ff[24:0];
      al[1] = s6_amag_ff[49:25];
      al[2] = {1'b0, s6_amag_ff[73:50]};
      cl[0] = s6_c_ff[24:0];
      cl[1] = s6_c_ff[49:25];
      cl[2] = s6_c_ff[74:50];
      cl[3] = {2'b00, s6_c_ff[97:75]};
      ml[0] = s6_m2_ff[23:0];
      ml[1] = s6_m2_ff[47:24];
      s7_ap_in[0] = al[0] * al[0];
      s7_ap_in[1] = al[1] * al[1];
      s7_ap_in[2] = al[2] * al[2];
      s7_ap_in[3] = al[0] * al[1];
      s7_ap_in[4] = al[0] * al[2];
      s7_ap_in[5] = al[1] * al[2];
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 4; j++) begin
            s7_mc_in[i*4+j] = ml[i] * cl[j];
         end
      end
   end

   // stage 8: A^2 and m2*C
   always_comb begin
      s8_a2_in = A2_W'(s7_ap_ff[0]) + (A2_W'(s7_ap_ff[1]) << 50)
               + (A2_W'(s7_ap_ff[2]) << 100) + (A2_W'(s7_ap_ff[3]) << 26)
               + (A2_W'(s7_ap_ff[4]) << 51) + (A2_W'(s7_ap_ff[5]) << 76);
      s8_mc_in = '0;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 4; j++) begin
            s8_mc_in = s8_mc_in + (MC_W'(s7_mc_ff[i*4+j]) << (24 * i + 25 * j));
         end
      end
   end

   // stage 9: denominator, enter the divide and root chain
   always_comb begin
      lane_in[0].bad = s8_bad_ff || ((s8_a2_ff == '0) && (s8_mc_ff == '0));
      lane_in[0].den = D_W'(s8_a2_ff) + D_W'(s8_mc_ff);
      lane_in[0].rem = (D_W + 1)'(s8_a2_ff);
      lane_in[0].quo = '0;
      lane_in[0].mx  = s8_m2_ff;
      lane_in[0].mr  = '0;
      lane_in[0].mq  = '0;
      lane_in[0].cx  = '0;
      lane_in[0].cr  = '0;
      lane_in[0].cq  = '0;
   end

   for (genvar k = 0; k < LONG_STEPS; k++) begin : g_step
      always_comb begin
         dbpam_stage_type cur;
         dbpam_stage_type nxt;
         logic [D_W+1:0]  trial;
         logic            ge;
         logic [D_W:0]    kept;
         logic [MR_W-1:0] m_rr;
         logic [MR_W-1:0] m_t;
         logic [CR_W-1:0] c_rr;
         logic [CR_W-1:0] c_t;
         cur   = lane_ff[k];
         trial = '0;
         ge    = 1'b0;
         kept  = '0;
         m_rr  = '0;
         m_t   = '0;
         c_rr  = '0;
         c_t   = '0;
         if (k == Q_W) begin
            cur.cx = {1'b0, cur.quo};
            cur.cr = '0;
            cur.cq = '0;
         end
         nxt = cur;
         if (k < Q_W) begin
            trial   = {1'b0, cur.rem} - {2'b00, cur.den};
            ge      = !trial[D_W+1];
            kept    = ge ? trial[D_W:0] : cur.rem;
            nxt.rem = {kept[D_W-1:0], 1'b0};
            nxt.quo = {cur.quo[Q_W-2:0], ge};
         end
         if (k < W) begin
            m_rr   = {cur.mr[MR_W-3:0], cur.mx[M2_W-1 -: 2]};
            m_t    = {cur.mq, 2'b01};
            nxt.mx = {cur.mx[M2_W-3:0], 2'b00};
            if (m_rr >= m_t) begin
               nxt.mr = m_rr - m_t;
               nxt.mq = {cur.mq[W-2:0], 1'b1};
            end else begin
               nxt.mr = m_rr;
               nxt.mq = {cur.mq[W-2:0], 1'b0};
            end
         end
         if (k >= Q_W) begin
            c_rr   = {cur.cr[CR_W-3:0], cur.cx[CX_W-1 -: 2]};
            c_t    = {cur.cq, 2'b01};
            nxt.cx = {cur.cx[CX_W-3:0], 2'b00};
            if (c_rr >= c_t) begin
               nxt.cr = c_rr - c_t;
               nxt.cq = {cur.cq[CQ_W-2:0], 1'b1};
            end else begin
               nxt.cr = c_rr;
               nxt.cq = {cur.cq[CQ_W-2:0], 1'b0};
            end
         end
         lane_in[k+1] = nxt;
      end
   end

   // output: saturate the angle, zero a rejected pair
   always_comb begin
      dbpam_stage_type fin;
      fin = lane_ff[LONG_STEPS];
      if (fin.bad) begin
         rsp_pair_mass_in = '0;
         rsp_angle_in     = '0;
         rsp_ok_in        = 1'b0;
      end else begin
         rsp_pair_mass_in = fin.mq;
         rsp_angle_in     = fin.cq[CQ_W-1] ? ANGLE_MAX : fin.cq[ANGLE_W-1:0];
         rsp_ok_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s1_p_ff[i]  <= s1_p_in[i];
            s1_s_ff[i]  <= s1_s_in[i];
            s2_sq_ff[i] <= s2_sq_in[i];
            s2_dp_ff[i] <= s2_dp_in[i];
            s2_pp_ff[i] <= s2_pp_in[i];
            s4_dd_ff[i] <= s4_dd_in[i];
         end
         s1_pe_ff  <= req_plus_energy;
         s1_se_ff  <= s1_se_in;

         s2_see_ff <= s2_see_in;
         s2_se_ff  <= s1_se_ff;
         s2_pe_ff  <= s1_pe_ff;

         s3_ppair_ff <= s3_ppair_in;
         s3_m2_ff    <= s3_m2_in;
         s3_bad_ff   <= s3_bad_in;
         s3_dmag_ff  <= s3_dmag_in;
         s3_dneg_ff  <= s3_dneg_in;
         s3_pone_ff  <= s3_pone_in;
         s3_se_ff    <= s2_se_ff;
         s3_pe_ff    <= s2_pe_ff;

         s4_ea_lo_ff <= s4_ea_lo_in;
         s4_ea_hi_ff <= s4_ea_hi_in;
         s4_pb_lo_ff <= s4_pb_lo_in;
         s4_pb_hi_ff <= s4_pb_hi_in;
         for (int i = 0; i < 4; i++) begin
            s4_cp_ff[i] <= s4_cp_in[i];
         end
         s4_m2_ff   <= s3_m2_ff;
         s4_bad_ff  <= s3_bad_ff;
         s4_dneg_ff <= s3_dneg_ff;

         s5_ea_ff   <= s5_ea_in;
         s5_pb_ff   <= s5_pb_in;
         s5_prod_ff <= s5_prod_in;
         s5_dsq_ff  <= s5_dsq_in;
         s5_m2_ff   <= s4_m2_ff;
         s5_bad_ff  <= s4_bad_ff;
         s5_dneg_ff <= s4_dneg_ff;

         s6_amag_ff <= s6_amag_in;
         s6_c_ff    <= s6_c_in;
         s6_m2_ff   <= s5_m2_ff;
         s6_bad_ff  <= s5_bad_ff;

         for (int i = 0; i < 6; i++) begin
            s7_ap_ff[i] <= s7_ap_in[i];
         end
         for (int i = 0; i < 8; i++) begin
            s7_mc_ff[i] <= s7_mc_in[i];
         end
         s7_m2_ff  <= s6_m2_ff;
         s7_bad_ff <= s6_bad_ff;

         s8_a2_ff  <= s8_a2_in;
         s8_mc_ff  <= s8_mc_in;
         s8_m2_ff  <= s7_m2_ff;
         s8_bad_ff <= s7_bad_ff;

         for (int i = 0; i <= LONG_STEPS; i++) begin
            lane_ff[i] <= lane_in[i];
         end

         rsp_pair_mass_ff <= rsp_pair_mass_in;
         rsp_angle_ff     <= rsp_angle_in;
         rsp_ok_ff        <= rsp_ok_in;
      end
   end

`ifndef SYNTHESIS
   a_freeze_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vld_ff))
      else $error("pipeline moved while the output transaction was stalled");

   a_remainder_bound : assert property (@(posedge clock) disable iff (reset)
      vld_ff[FRONT_STAGES+1] && !lane_ff[1].bad |->
         lane_ff[1].rem < {lane_ff[1].den, 1'b0})
      else $error("divide remainder out of range");

   a_rejected_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_valid |->
         (rsp_pair_mass == '0) && (rsp_abs_cos_angle == '0))
      else $error("rejected pair carries nonzero results");
`endif

endmodule

// ===== sim/dbpam_checker.sv =====
// Checker for the diboson pair mass and polar angle block: predicts and compares each transaction.
module dbpam_checker (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   input  logic                                        req_stall,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_plus_px,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_plus_py,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_plus_pz,
   input  logic        [dbpam_pkg::ENERGY_W-1:0]       req_plus_energy,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_minus_px,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_minus_py,
   input  logic signed [dbpam_pkg::MOMENTUM_WIDTH-1:0] req_minus_pz,
   input  logic        [dbpam_pkg::ENERGY_W-1:0]       req_minus_energy,
   input  logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   input  logic        [dbpam_pkg::MOMENTUM_WIDTH-1:0] rsp_pair_mass,
   input  logic        [dbpam_pkg::ANGLE_W-1:0]        rsp_abs_cos_angle,
   input  logic                                        rsp_result_valid,
   output int                                          fail_count,
   output int                                          pending_count
);
   import dbpam_pkg::*;

   typedef struct packed {
      logic [W-1:0]       mass;
      logic [ANGLE_W-1:0] cosine;
      logic               ok;
   } pair_result_type;

   typedef logic signed [255:0] big_type;

   pair_result_type pair_results_q[$];

   function automatic logic [W-1:0] mass_root(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         b = r | (64'd1 << i);
         if (b * b <= x) r = b;
      end
      return (r > {W{1'b1}}) ? {W{1'b1}} : r[W-1:0];
   endfunction

   function automatic pair_result_type predict_pair(
      input logic signed [W-1:0] ax, ay, az,
      input logic [ENERGY_W-1:0] ae,
      input logic signed [W-1:0] bx, by, bz,
      input logic [ENERGY_W-1:0] be);
      big_type px, py, pz, pe, sx, sy, sz, se, ppair, m2, dt, pone, a, c, d, num, lhs;
      logic [16:0] q, t;
      pair_result_type r;
      px = ax; py = ay; pz = az; pe = $signed({1'b0, ae});
      sx = px + big_type'(bx); sy = py + big_type'(by); sz = pz + big_type'(bz);
      se = pe + $signed({1'b0, be});
      ppair = sx * sx + sy * sy + sz * sz;
      m2 = se * se - ppair;
      dt = px * sx + py * sy + pz * sz;
      pone = px * px + py * py + pz * pz;
      a = se * dt - ppair * pe;
      c = pone * ppair - dt * dt;
      d = a * a + m2 * c;
      r = '0;
      if (m2 <= 0 || ppair == 0 || d == 0) return r;
      r.mass = mass_root(m2[63:0]);
      num = (a * a) <<< 32;
      q = 0;
      for (int i = 15; i >= 0; i--) begin
         t = q | (17'd1 << i);
         lhs = big_type'(t) * big_type'(t) * d;
         if (lhs <= num) q = t;
      end
      r.cosine = (q > ANGLE_MAX) ? ANGLE_MAX : q[ANGLE_W-1:0];
      r.ok = 1'b1;
      return r;
   endfunction

   assign pending_count = pair_results_q.size();

   always @(posedge clock) begin
      pair_result_type exp_r;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            pair_results_q.insert(pair_results_q.size(),
               predict_pair(req_plus_px, req_plus_py, req_plus_pz, req_plus_energy,
                            req_minus_px, req_minus_py, req_minus_pz, req_minus_energy));
         if (rsp_valid && !rsp_stall) begin
            if (pair_results_q.size() == 0) begin
               $error("unexpected transaction");
               fail_count <= fail_count + 1;
            end else begin
               exp_r = pair_results_q.pop_front();
               if (exp_r.mass !== rsp_pair_mass || exp_r.cosine !== rsp_abs_cos_angle ||
                   exp_r.ok !== rsp_result_valid) begin
                  if (exp_r.mass !== rsp_pair_mass)
                     $error("pair_mass exp %0d got %0d", exp_r.mass, rsp_pair_mass);
                  if (exp_r.cosine !== rsp_abs_cos_angle)
                     $error("abs_cos_angle exp %0d got %0d", exp_r.cosine,
                            rsp_abs_cos_angle);
                  if (exp_r.ok !== rsp_result_valid)
                     $error("result_valid exp %0d got %0d", exp_r.ok, rsp_result_valid);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the diboson pair mass and polar angle block: stimulus and verdict.
module tb;
   import dbpam_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [W-1:0] req_plus_px = 0, req_plus_py = 0, req_plus_pz = 0;
   logic signed [W-1:0] req_minus_px = 0, req_minus_py = 0, req_minus_pz = 0;
   logic [ENERGY_W-1:0] req_plus_energy = 0, req_minus_energy = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [W-1:0] rsp_pair_mass;
   logic [ANGLE_W-1:0] rsp_abs_cos_angle;
   logic rsp_result_valid;
   int fail_count, pending_count;
   int send_idle_pct = 0, stall_pct = 0;

   diboson_polar_angle_and_mass u_dut (.*);
   dbpam_checker u_checker (.*);

   initial forever #4 clock = ~clock;

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   function automatic logic signed [W-1:0] rand_momentum();
      case ($urandom_range(3))
         0: return W'($urandom);
         1: return $signed(W'($urandom_range(4095))) - $signed(W'(2048));
         2: return $signed(W'($urandom_range(200000))) - $signed(W'(100000));
         default: return $urandom_range(1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
      endcase
   endfunction

   task automatic send_event(input logic signed [W-1:0] ax, ay, az,
                             input logic [ENERGY_W-1:0] ae,
                             input logic signed [W-1:0] bx, by, bz,
                             input logic [ENERGY_W-1:0] be);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_plus_px <= ax; req_plus_py <= ay; req_plus_pz <= az; req_plus_energy <= ae;
      req_minus_px <= bx; req_minus_py <= by; req_minus_pz <= bz; req_minus_energy <= be;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random();
      logic signed [W-1:0] ax, ay, az, bx, by, bz;
      logic [ENERGY_W-1:0] ae, be;
      ax = rand_momentum(); ay = rand_momentum(); az = rand_momentum();
      bx = rand_momentum(); by = rand_momentum(); bz = rand_momentum();
      ae = ENERGY_W'($urandom); be = ENERGY_W'($urandom);
      if ($urandom_range(9) < 7) begin
         ax = ax >>> 3; ay = ay >>> 3; az = az >>> 3;
         bx = bx >>> 3; by = by >>> 3; bz = bz >>> 3;
         ae = ENERGY_W'($urandom_range(2 * 1048576, 0) + 1048576 * 2);
         be = ENERGY_W'($urandom_range(2 * 1048576, 0) + 1048576 * 2);
      end
      send_event(ax, ay, az, ae, bx, by, bz, be);
   endtask

   initial begin
      localparam logic signed [W-1:0] PMAX = {1'b0, {(W-1){1'b1}}};
      localparam logic signed [W-1:0] PMIN = {1'b1, {(W-1){1'b0}}};
      localparam logic [ENERGY_W-1:0] EMAX = '1;
      int phase;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_event(0, 0, 0, 0, 0, 0, 0, 0);
      send_event(0, 0, 0, 1024, 0, 0, 0, 1024);
      send_event(1000, 0, 0, 5000, -1000, 0, 0, 5000);
      send_event(1000, 0, 0, 1000, 0, 0, 0, 0);
      send_event(1000, 2000, 3000, 100, 5, 5, 5, 10);
      send_event(PMAX, PMAX, PMAX, EMAX, PMAX, PMAX, PMAX, EMAX);
      send_event(PMIN, PMIN, PMIN, EMAX, PMIN, PMIN, PMIN, EMAX);
      send_event(PMAX, 0, 0, EMAX, PMIN, 0, 0, EMAX);
      send_event(0, 0, 0, EMAX, 0, 0, 1000, EMAX);
      send_event(0, 0, 1000, 50000, 0, 0, 1000, 50000);
      send_event(0, 0, 3000, 5000, 0, 0, -1000, 5000);
      send_event(100, 0, 0, 0, 0, 0, 0, 20000);
      send_event(0, 0, 0, 5000, 0, 0, 1000, 5000);
      send_event(1, -1, 1, 3, -1, 1, -1, 2);
      send_event(-1, -1, -1, 0, -1, -1, -1, EMAX);
      send_event(4000, 0, 0, 5000, 0, 3000, 0, 5000);
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 56 : 13) : 0;
         stall_pct = (phase == 2) ? 56 : ((phase == 3) ? 13 : 0);
         repeat (360) send_random();
      end
      send_idle_pct = 0; stall_pct = 0;
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/dbpam_pkg.sv
hdl/diboson_polar_angle_and_mass.sv
sim/dbpam_checker.sv
sim/tb.sv
